// ----- rtl/core/binary_min_heap_queue_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Heap queue assertion macros
// Shorthand for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BMHQ_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// Heap queue package
// Sizes, codes and request types shared by the heap queue modules.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int DEPTH        = 256;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int KEY_W        = 32;
    localparam int HANDLE_W     = 16;
    localparam int ITEM_COUNT_W = 9;
    localparam int ENTRY_W      = KEY_W + HANDLE_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_DEL_LAST,
        S_DN_RIGHT,
        S_DN_CMP,
        S_FINAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        t_cmd                command;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_in_req;

    typedef struct packed {
        t_status                 status;
        logic [KEY_W-1:0]        removed_key;
        logic [HANDLE_W-1:0]     removed_handle;
        logic [KEY_W-1:0]        min_key;
        logic [HANDLE_W-1:0]     min_handle;
        logic [ITEM_COUNT_W-1:0] item_count;
        logic                    is_empty;
    } t_out_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        t_status          status;
        t_entry           removed;
        t_entry           root;
        logic [CNT_W-1:0] count;
    } t_result;

endpackage

// ----- rtl/core/bmhq_ram.sv -----
// ----------------------------------------------------------------------------
// Heap queue storage RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH   = 48,
    parameter int DEPTH_P = 256,
    parameter int AW      = $clog2(DEPTH_P)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH_P];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/bmhq_sift.sv -----
// ----------------------------------------------------------------------------
// Heap queue sift sequencer
// Walks the heap one level at a time for insert and delete-minimum.
// ----------------------------------------------------------------------------
module bmhq_sift
    import bmhq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_in_req i_req,
    output logic    o_busy,
    output logic    o_done,
    input  logic    i_done_ack,
    output t_result o_result,
    output t_mem_wr o_wr,
    output t_mem_rd o_rd,
    input  t_entry  i_rd_data
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [CNT_W-1:0] r_pos, n_pos;
    t_entry           r_item, n_item;
    t_entry           r_left, n_left;
    logic             r_has_right, n_has_right;
    t_entry           r_root, n_root;
    t_entry           r_removed, n_removed;
    t_status          r_status, n_status;

    // Shared move comparator: operands depend on the sift direction.
    logic [KEY_W-1:0] cmp_lhs;
    logic [KEY_W-1:0] cmp_rhs;
    logic             cmp_lt;

    logic             right_lt;
    logic             take_right;
    t_entry           child;
    logic [CNT_W-1:0] child_pos;
    logic [CNT_W:0]   grand_pos;
    logic [CNT_W-1:0] left_pos;
    logic [CNT_W-1:0] up_pos;
    logic [CNT_W-1:0] occ_inc;

    function automatic logic [ADDR_W-1:0] slot(input logic [CNT_W-1:0] pos);
        logic [CNT_W-1:0] s;
        s = pos - CNT_W'(1);
        return s[ADDR_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_item      <= n_item;
        r_left      <= n_left;
        r_has_right <= n_has_right;
        r_root      <= n_root;
        r_removed   <= n_removed;
        r_status    <= n_status;
    end

    assign right_lt   = i_rd_data.key < r_left.key;
    assign take_right = r_has_right && right_lt;
    assign child      = take_right ? i_rd_data : r_left;
    assign left_pos   = CNT_W'({r_pos, 1'b0});
    assign child_pos  = left_pos + CNT_W'(take_right);
    assign grand_pos  = {child_pos, 1'b0};
    assign up_pos     = r_pos >> 1;
    assign occ_inc    = r_occ + CNT_W'(1);

    always_comb begin
        if (r_state == S_UP_CMP) begin
            cmp_lhs = r_item.key;
            cmp_rhs = i_rd_data.key;
        end else begin
            cmp_lhs = child.key;
            cmp_rhs = r_item.key;
        end
    end

    assign cmp_lt = cmp_lhs < cmp_rhs;

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_pos       = r_pos;
        n_item      = r_item;
        n_left      = r_left;
        n_has_right = r_has_right;
        n_root      = r_root;
        n_removed   = r_removed;
        n_status    = r_status;
        o_wr        = '{en: 1'b0, addr: '0, data: r_item};
        o_rd        = '{en: 1'b0, addr: '0};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item    = '{key: i_req.key, handle: i_req.handle};
                    n_removed = '0;
                    n_status  = ST_OK;
                    n_state   = S_DONE;
                    case (i_req.command)
                        CMD_INSERT: begin
                            if (r_occ == CNT_W'(DEPTH)) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_occ = occ_inc;
                                n_pos = occ_inc;
                                if (r_occ == '0) begin
                                    o_wr   = '{en: 1'b1, addr: '0,
                                               data: '{key: i_req.key, handle: i_req.handle}};
                                    n_root = '{key: i_req.key, handle: i_req.handle};
                                end else begin
                                    o_rd    = '{en: 1'b1, addr: slot(occ_inc >> 1)};
                                    n_state = S_UP_CMP;
                                end
                            end
                        end
                        CMD_DELETE: begin
                            if (r_occ == '0) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                n_removed = r_root;
                                n_occ     = r_occ - CNT_W'(1);
                                if (r_occ != CNT_W'(1)) begin
                                    o_rd    = '{en: 1'b1, addr: slot(r_occ)};
                                    n_state = S_DEL_LAST;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            n_occ = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_UP_CMP: begin
                if (cmp_lt) begin
                    // Parent moves down into the hole; the hole moves up.
                    o_wr  = '{en: 1'b1, addr: slot(r_pos), data: i_rd_data};
                    n_pos = up_pos;
                    if (up_pos == CNT_W'(1)) begin
                        n_state = S_FINAL;
                    end else begin
                        o_rd = '{en: 1'b1, addr: slot(up_pos >> 1)};
                    end
                end else begin
                    o_wr    = '{en: 1'b1, addr: slot(r_pos), data: r_item};
                    n_state = S_DONE;
                end
            end

            S_DEL_LAST: begin
                n_item = i_rd_data;
                n_pos  = CNT_W'(1);
                if (r_occ >= CNT_W'(2)) begin
                    o_rd    = '{en: 1'b1, addr: slot(CNT_W'(2))};
                    n_state = S_DN_RIGHT;
                end else begin
                    o_wr    = '{en: 1'b1, addr: '0, data: i_rd_data};
                    n_root  = i_rd_data;
                    n_state = S_DONE;
                end
            end

            S_DN_RIGHT: begin
                n_left      = i_rd_data;
                n_has_right = left_pos != r_occ;
                if (left_pos != r_occ) begin
                    o_rd = '{en: 1'b1, addr: slot(left_pos + CNT_W'(1))};
                end
                n_state = S_DN_CMP;
            end

            S_DN_CMP: begin
                if (cmp_lt) begin
                    o_wr = '{en: 1'b1, addr: slot(r_pos), data: child};
                    if (r_pos == CNT_W'(1)) begin
                        n_root = child;
                    end
                    n_pos = child_pos;
                    if (grand_pos <= {1'b0, r_occ}) begin
                        o_rd    = '{en: 1'b1, addr: slot(grand_pos[CNT_W-1:0])};
                        n_state = S_DN_RIGHT;
                    end else begin
                        n_state = S_FINAL;
                    end
                end else begin
                    o_wr = '{en: 1'b1, addr: slot(r_pos), data: r_item};
                    if (r_pos == CNT_W'(1)) begin
                        n_root = r_item;
                    end
                    n_state = S_DONE;
                end
            end

            S_FINAL: begin
                o_wr = '{en: 1'b1, addr: slot(r_pos), data: r_item};
                if (r_pos == CNT_W'(1)) begin
                    n_root = r_item;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_done_ack) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = r_state != S_IDLE;
    assign o_done   = r_state == S_DONE;
    assign o_result = '{status: r_status, removed: r_removed, root: r_root, count: r_occ};

endmodule

// ----- rtl/core/binary_min_heap_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Binary min-heap priority queue
// Keeps (key, handle) pairs in a heap in RAM and serves insert, delete-minimum
// and clear requests, one at a time.
// ----------------------------------------------------------------------------
// Usage: a request enters on i_in_req when i_in_valid is high and o_in_stall is
// low. Insert places the pair and sifts it up; delete-minimum returns the root,
// moves the last entry to the root and sifts it down; clear empties the heap.
// Each request gives exactly one result on o_out_req, held while i_out_stall
// is high. Latency with a ready receiver is set by the single RAM read port
// and the shared move comparator that walk the heap a level at a time. An
// insert into a non-empty heap reads the parent and climbs, with a last write
// at the root if it gets there; a delete-minimum that leaves two or more
// entries reads the last entry and descends, with a last write if it reaches
// the bottom; one that leaves a single entry moves the last entry to the root.
// Clear, overflow, underflow, an unused command, an insert into an empty heap
// and a delete of the only entry walk no levels. o_in_stall stays high from
// acceptance until the result has moved into the output register, so the next
// request is taken in the cycle after the result appears. If the receiver
// stalls, the result waits in the output register and the next request may
// still be worked on; its result waits in the sequencer until the register
// frees up. Reset empties the heap at once; RAM contents are never cleared,
// since only written positions are ever read.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_unit_assert.svh"

module binary_min_heap_queue_unit
    import bmhq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    logic     seq_busy;
    logic     seq_done;
    logic     load_out;
    t_result  seq_result;
    t_mem_wr  mem_wr;
    t_mem_rd  mem_rd;
    t_entry   mem_rd_data;

    logic     r_out_valid, n_out_valid;
    t_out_req r_out_req, n_out_req;

    // The sequencer owns the heap walk; this level only holds the result.
    bmhq_sift u_sift (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && !seq_busy),
        .i_req      (i_in_req),
        .o_busy     (seq_busy),
        .o_done     (seq_done),
        .i_done_ack (load_out),
        .o_result   (seq_result),
        .o_wr       (mem_wr),
        .o_rd       (mem_rd),
        .i_rd_data  (mem_rd_data)
    );

    // Keys and handles share one RAM word so each entry costs a single read.
    bmhq_ram #(
        .WIDTH   (ENTRY_W),
        .DEPTH_P (DEPTH),
        .AW      (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr.en),
        .i_wr_addr (mem_wr.addr),
        .i_wr_data (mem_wr.data),
        .i_rd_en   (mem_rd.en),
        .i_rd_addr (mem_rd.addr),
        .o_rd_data (mem_rd_data)
    );

    assign o_in_stall = seq_busy;

    // A finished result moves into the output register whenever that register
    // is empty or is being drained in the same cycle.
    assign load_out = seq_done && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_req   = r_out_req;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid                = 1'b1;
            n_out_req.status           = seq_result.status;
            n_out_req.removed_key      = seq_result.removed.key;
            n_out_req.removed_handle   = seq_result.removed.handle;
            n_out_req.item_count       = ITEM_COUNT_W'(seq_result.count);
            n_out_req.is_empty         = seq_result.count == '0;
            // The root register may be stale once the heap is empty.
            if (seq_result.count == '0) begin
                n_out_req.min_key    = '0;
                n_out_req.min_handle = '0;
            end else begin
                n_out_req.min_key    = seq_result.root.key;
                n_out_req.min_handle = seq_result.root.handle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_req <= n_out_req;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    // Checks on the sequencer and the result formatting.
    `BMHQ_ASSERT_NOW(a_count_range,
        !o_out_valid || (o_out_req.item_count <= ITEM_COUNT_W'(DEPTH)),
        "item count above depth")
    `BMHQ_ASSERT_NOW(a_empty_min_zero,
        !o_out_valid || !o_out_req.is_empty ||
        (o_out_req.min_key == '0 && o_out_req.min_handle == '0),
        "empty heap reports a minimum")
    `BMHQ_ASSERT_NOW(a_underflow_clean,
        !o_out_valid || (o_out_req.status != ST_UNDERFLOW) ||
        (o_out_req.removed_key == '0 && o_out_req.item_count == '0),
        "underflow with items or a removed key")
    `BMHQ_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall,
        "sequencer not busy after a request")

endmodule

// ----- test/tb_binary_min_heap_queue_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap queue unit testbench
// Drives insert, delete-minimum, clear and unused requests into the heap
// queue under changing idle and stall patterns. A behavioral heap inside the
// bench predicts every result, and the results are compared field by field.
// ----------------------------------------------------------------------------
module tb_binary_min_heap_queue_unit;
    import bmhq_pkg::*;

    // The unused command code has no member in the package enum.
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         MIX_ITEMS   = 125;
    localparam int         HOLD_CYCLES = 300;
    localparam int         DRAIN_WAIT  = 40;

    typedef struct packed {
        t_in_req  req;
        logic     typed;
        t_out_req want;
    } t_stim_row;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_req    = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_req;

    // Behavioral heap: positions 1..heap_fill are live.
    t_entry      heap_store [1:DEPTH];
    int unsigned heap_fill = 0;

    t_out_req    pending_results [$];
    t_stim_row   directed_rows [$];
    int          mismatch_count   = 0;
    int          cycle_count      = 0;
    int          sender_idle_pct  = 0;
    int          recv_stall_pct   = 0;
    bit          long_hold_pending = 1'b0;

    binary_min_heap_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Applies one request to the behavioral heap and returns its result.
    function automatic t_out_req heap_model_step(input t_in_req req);
        t_out_req    res;
        t_entry      moved;
        int unsigned pos;
        int unsigned child;
        bit          settled;
        begin
            res = '0;
            res.status = ST_OK;
            case (req.command)
                CMD_INSERT: begin
                    if (heap_fill >= DEPTH) begin
                        res.status = ST_OVERFLOW;
                    end else begin
                        // Climb only past strictly larger parents, so equal keys
                        // keep their arrival order on the way up.
                        heap_fill++;
                        pos = heap_fill;
                        while (pos > 1 && req.key < heap_store[pos / 2].key) begin
                            heap_store[pos] = heap_store[pos / 2];
                            pos = pos / 2;
                        end
                        heap_store[pos] = '{key: req.key, handle: req.handle};
                    end
                end
                CMD_DELETE: begin
                    if (heap_fill == 0) begin
                        res.status = ST_UNDERFLOW;
                    end else begin
                        res.removed_key    = heap_store[1].key;
                        res.removed_handle = heap_store[1].handle;
                        moved = heap_store[heap_fill];
                        heap_fill--;
                        pos = 1;
                        settled = 1'b0;
                        // The right child wins only when strictly smaller; a tie
                        // keeps the left one.
                        while (!settled && pos * 2 <= heap_fill) begin
                            child = pos * 2;
                            if (child != heap_fill &&
                                heap_store[child + 1].key < heap_store[child].key) begin
                                child++;
                            end
                            if (heap_store[child].key < moved.key) begin
                                heap_store[pos] = heap_store[child];
                                pos = child;
                            end else begin
                                settled = 1'b1;
                            end
                        end
                        if (heap_fill > 0) begin
                            heap_store[pos] = moved;
                        end
                    end
                end
                CMD_CLEAR: begin
                    heap_fill = 0;
                end
                default: begin
                    // The unused code leaves the heap alone.
                end
            endcase
            if (heap_fill > 0) begin
                res.min_key    = heap_store[1].key;
                res.min_handle = heap_store[1].handle;
            end
            res.item_count = ITEM_COUNT_W'(heap_fill);
            res.is_empty   = (heap_fill == 0);
            return res;
        end
    endfunction

    // Offers one request, waits for its acceptance, then records what it
    // should produce: the typed value when given, else the prediction.
    task automatic send_request(input t_in_req req, input logic typed, input t_out_req want);
        t_out_req predicted;
        begin
            while ($urandom_range(99) < sender_idle_pct) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            @(negedge i_clk);
            i_in_valid <= 1'b1;
            i_in_req   <= req;
            do @(posedge i_clk); while (o_in_stall);
            predicted = heap_model_step(req);
            pending_results.push_back(typed ? want : predicted);
        end
    endtask

    task automatic add_row(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [HANDLE_W-1:0] handle, input logic typed,
                           input t_status st, input logic [KEY_W-1:0] rk,
                           input logic [HANDLE_W-1:0] rh, input logic [KEY_W-1:0] mk,
                           input logic [HANDLE_W-1:0] mh,
                           input logic [ITEM_COUNT_W-1:0] cnt, input logic empty);
        t_stim_row row;
        begin
            row.req  = '{command: t_cmd'(cmd), key: key, handle: handle};
            row.typed = typed;
            row.want = '{status: st, removed_key: rk, removed_handle: rh, min_key: mk,
                         min_handle: mh, item_count: cnt, is_empty: empty};
            directed_rows.push_back(row);
        end
    endtask

    // Keys lean toward a narrow range so that ties are frequent.
    function automatic logic [KEY_W-1:0] pick_key();
        begin
            case ($urandom_range(9))
                0:       return '0;
                1:       return '1;
                2, 3, 4: return KEY_W'($urandom_range(7));
                default: return KEY_W'($urandom());
            endcase
        end
    endfunction

    function automatic t_in_req random_request(input logic [1:0] cmd);
        t_in_req req;
        begin
            req.command = t_cmd'(cmd);
            req.key     = pick_key();
            req.handle  = HANDLE_W'($urandom_range(16'hFFFF));
            return req;
        end
    endfunction

    // Receiver: random stalls, plus one long hold-off on request so that the
    // output register and the sequencer fill and the input stalls.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Result checker: every accepted result is matched against the oldest
    // expectation.
    always @(posedge i_clk) begin : check_results
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %h", o_out_req);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_req.status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_req.status);
                    mismatch_count++;
                end
                if (o_out_req.removed_key != want.removed_key) begin
                    $error("removed_key: expected %0h, got %0h",
                           want.removed_key, o_out_req.removed_key);
                    mismatch_count++;
                end
                if (o_out_req.removed_handle != want.removed_handle) begin
                    $error("removed_handle: expected %0h, got %0h",
                           want.removed_handle, o_out_req.removed_handle);
                    mismatch_count++;
                end
                if (o_out_req.min_key != want.min_key) begin
                    $error("min_key: expected %0h, got %0h", want.min_key, o_out_req.min_key);
                    mismatch_count++;
                end
                if (o_out_req.min_handle != want.min_handle) begin
                    $error("min_handle: expected %0h, got %0h",
                           want.min_handle, o_out_req.min_handle);
                    mismatch_count++;
                end
                if (o_out_req.item_count != want.item_count) begin
                    $error("item_count: expected %0d, got %0d",
                           want.item_count, o_out_req.item_count);
                    mismatch_count++;
                end
                if (o_out_req.is_empty != want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, o_out_req.is_empty);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int          phase;
        int          pick;
        logic [1:0]  cmd;
        t_in_req     req;

        // Directed rows. Results are typed in where they are obvious: the
        // empty heap, the extreme keys and the error codes.
        add_row(CMD_DELETE, '0, '0, 1'b1, ST_UNDERFLOW, '0, '0, '0, '0, 9'd0, 1'b1);
        add_row(CMD_CLEAR, '0, '0, 1'b1, ST_OK, '0, '0, '0, '0, 9'd0, 1'b1);
        add_row(CMD_UNUSED, '1, '1, 1'b1, ST_OK, '0, '0, '0, '0, 9'd0, 1'b1);
        add_row(CMD_INSERT, '1, '1, 1'b1, ST_OK, '0, '0, '1, '1, 9'd1, 1'b0);
        add_row(CMD_INSERT, '0, '0, 1'b1, ST_OK, '0, '0, '0, '0, 9'd2, 1'b0);
        add_row(CMD_INSERT, 32'd5, 16'h1234, 1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_INSERT, 32'd5, 16'h4321, 1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_INSERT, 32'd5, 16'hAAAA, 1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_INSERT, 32'd3, 16'h5555, 1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_UNUSED, 32'h1234_5678, 16'h9ABC, 1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_DELETE, '0, '0, 1'b1, ST_OK, '0, '0, 32'd3, 16'h5555, 9'd5, 1'b0);
        add_row(CMD_DELETE, '0, '0, 1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_DELETE, '0, '0, 1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_DELETE, '0, '0, 1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_DELETE, '0, '0, 1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_DELETE, '0, '0, 1'b1, ST_OK, '1, '1, '0, '0, 9'd0, 1'b1);
        add_row(CMD_DELETE, '1, '1, 1'b1, ST_UNDERFLOW, '0, '0, '0, '0, 9'd0, 1'b1);
        add_row(CMD_INSERT, 32'h5555_5555, 16'hAAAA, 1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_INSERT, 32'hAAAA_AAAA, 16'h5555, 1'b0, ST_OK, '0, '0, '0, '0, '0, 1'b0);
        add_row(CMD_CLEAR, '1, '1, 1'b1, ST_OK, '0, '0, '0, '0, 9'd0, 1'b1);
        add_row(CMD_DELETE, '0, '0, 1'b1, ST_UNDERFLOW, '0, '0, '0, '0, 9'd0, 1'b1);
        add_row(CMD_INSERT, 32'h8000_0000, 16'h8000, 1'b1, ST_OK, '0, '0, 32'h8000_0000,
                16'h8000, 9'd1, 1'b0);
        add_row(CMD_DELETE, '0, '0, 1'b1, ST_OK, 32'h8000_0000, 16'h8000, '0, '0, 9'd0, 1'b1);

        // Synchronous reset, released on a falling clock edge.
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases, rotating through the idle and stall patterns.
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 46; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin sender_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            // A long hold-off while the sender keeps offering requests.
            if (phase == 4) begin
                long_hold_pending = 1'b1;
            end
            if (phase == 3) begin
                // Fill to the brim, knock on the full heap, drain it and
                // knock on the empty one.
                while (heap_fill < DEPTH) begin
                    send_request(random_request(CMD_INSERT), 1'b0, '0);
                end
                repeat (3) send_request(random_request(CMD_INSERT), 1'b0, '0);
                send_request(random_request(CMD_UNUSED), 1'b0, '0);
                while (heap_fill > 0) begin
                    send_request(random_request(CMD_DELETE), 1'b0, '0);
                end
                repeat (2) send_request(random_request(CMD_DELETE), 1'b0, '0);
            end else begin
                repeat (MIX_ITEMS) begin
                    pick = $urandom_range(99);
                    if (pick < 55) begin
                        cmd = CMD_INSERT;
                    end else if (pick < 93) begin
                        cmd = CMD_DELETE;
                    end else if (pick < 97) begin
                        cmd = CMD_CLEAR;
                    end else begin
                        cmd = CMD_UNUSED;
                    end
                    req = random_request(cmd);
                    send_request(req, 1'b0, '0);
                end
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        // A stray result after the last one would show up here.
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- binary_min_heap_queue_unit.f -----
+incdir+rtl/core
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_ram.sv
rtl/core/bmhq_sift.sv
rtl/core/binary_min_heap_queue_unit.sv
test/tb_binary_min_heap_queue_unit.sv
